// ===== rtl/core/cbz_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbz_pkg
// shared types and constants of the cubic bezier evaluate / split pipeline
// ----------------------------------------------------------------------------
package cbz_pkg;

   localparam int COORD_W       = 32;
   localparam int CBZ_FRAC_BITS = 16;
   localparam int SPLIT_LEFT    = 6;

   localparam logic MODE_EVAL  = 1'b0;
   localparam logic MODE_SPLIT = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef struct packed {
      point_type p0;
      point_type p1;
      point_type p2;
      point_type p3;
   } seg_type;

   typedef struct packed {
      logic      mode;
      logic      zs;
      seg_type   seg;
      point_type q01;
      point_type q12;
      point_type q23;
      point_type r0;
      point_type r1;
      point_type s;
   } carry_type;

endpackage
`default_nettype wire

// ===== rtl/core/cbz_lerp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbz_lerp
// a + round((b - a) * t), three register stages: difference, product, sum
// ----------------------------------------------------------------------------
module cbz_lerp
   import cbz_pkg::*;
#(
   parameter int FRAC_BITS = CBZ_FRAC_BITS
) (
   input  wire logic               clock,
   input  wire coord_type          a,
   input  wire coord_type          b,
   input  wire logic [FRAC_BITS:0] t,
   output coord_type               r
);

   localparam int PW = COORD_W + FRAC_BITS + 3;

   logic signed [COORD_W:0] d_in;
   logic signed [COORD_W:0] d_ff;
   coord_type               a1_ff;
   logic [FRAC_BITS:0]      t1_ff;
   logic signed [PW-1:0]    prod_in;
   logic signed [PW-1:0]    prod_ff;
   coord_type               a2_ff;
   logic signed [PW-1:0]    half;
   logic signed [PW-1:0]    sum;
   logic signed [PW-1:0]    sh;
   coord_type               r_in;
   coord_type               r_ff;

   always_comb begin
      d_in    = $signed({b[COORD_W-1], b}) - $signed({a[COORD_W-1], a});
      prod_in = d_ff * $signed({1'b0, t1_ff});
      half    = PW'(1) << (FRAC_BITS - 1);
      sum     = prod_ff + half;
      sh      = sum >>> FRAC_BITS;
      r_in    = a2_ff + $signed(sh[COORD_W-1:0]);
   end

   always_ff @(posedge clock) begin
      d_ff    <= d_in;
      a1_ff   <= a;
      t1_ff   <= t;
      prod_ff <= prod_in;
      a2_ff   <= a1_ff;
      r_ff    <= r_in;
   end

   assign r = r_ff;

endmodule
`default_nettype wire

// ===== rtl/core/cubic_bezier_eval_split.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_bezier_eval_split
// cubic bezier segment evaluation and de casteljau split, fully pipelined
//
//   channel  ports           handshake
//   input    start, req_*    taken when start is high and busy is low
//   result   rsp_*           one word per cycle while rsp_strobe is high
//
// an evaluate word enters every cycle while busy is low. a split word gives
// seven result words on consecutive cycles; busy stays high from its
// acceptance to its last result, so the rate there is set by the seven-word
// output sequencer. the time divider is one quotient bit per stage. reset
// clears all valid bits; results cannot be held off.
// ----------------------------------------------------------------------------
module cubic_bezier_eval_split
   import cbz_pkg::*;
#(
   parameter int FRAC_BITS = CBZ_FRAC_BITS
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      start,
   output logic           busy,
   input  wire logic      req_mode,
   input  wire coord_type req_query_time,
   input  wire coord_type req_start_x,
   input  wire coord_type req_start_y,
   input  wire coord_type req_out_handle_x,
   input  wire coord_type req_out_handle_y,
   input  wire coord_type req_in_handle_x,
   input  wire coord_type req_in_handle_y,
   input  wire coord_type req_end_x,
   input  wire coord_type req_end_y,
   output logic           rsp_strobe,
   output coord_type      rsp_point_x,
   output coord_type      rsp_point_y,
   output logic           rsp_last_point,
   output logic           rsp_zero_span
);

   localparam int NLV = 9;

   logic accept;
   assign accept = start && !busy;

   // front: differences
   logic                  s1_vld_ff;
   logic                  s1_mode_ff;
   seg_type               s1_seg_ff;
   logic signed [COORD_W:0] s1_num_ff;
   logic signed [COORD_W:0] s1_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_mode_ff   <= req_mode;
      s1_seg_ff.p0 <= '{x: req_start_x, y: req_start_y};
      s1_seg_ff.p1 <= '{x: req_out_handle_x, y: req_out_handle_y};
      s1_seg_ff.p2 <= '{x: req_in_handle_x, y: req_in_handle_y};
      s1_seg_ff.p3 <= '{x: req_end_x, y: req_end_y};
      s1_num_ff    <= $signed({req_query_time[COORD_W-1], req_query_time})
                    - $signed({req_start_x[COORD_W-1], req_start_x});
      s1_den_ff    <= $signed({req_end_x[COORD_W-1], req_end_x})
                    - $signed({req_start_x[COORD_W-1], req_start_x});
   end

   // magnitudes and zero-time flags
   logic               s2_vld_ff;
   logic               s2_mode_ff;
   logic               s2_zs_ff;
   logic               s2_tz_ff;
   seg_type            s2_seg_ff;
   logic [COORD_W:0]   s2_an_ff;
   logic [COORD_W:0]   s2_ad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_mode_ff <= s1_mode_ff;
      s2_seg_ff  <= s1_seg_ff;
      s2_zs_ff   <= (s1_den_ff == '0);
      s2_tz_ff   <= (s1_num_ff == '0) || (s1_num_ff[COORD_W] != s1_den_ff[COORD_W])
                 || (s1_den_ff == '0);
      s2_an_ff   <= s1_num_ff[COORD_W] ? (~s1_num_ff + 1'b1) : s1_num_ff;
      s2_ad_ff   <= s1_den_ff[COORD_W] ? (~s1_den_ff + 1'b1) : s1_den_ff;
   end

   // restoring divider, one quotient bit per stage
   logic                 dv_vld_ff  [FRAC_BITS];
   logic                 dv_mode_ff [FRAC_BITS];
   logic                 dv_zs_ff   [FRAC_BITS];
   logic                 dv_tz_ff   [FRAC_BITS];
   logic                 dv_sat_ff  [FRAC_BITS];
   seg_type              dv_seg_ff  [FRAC_BITS];
   logic [COORD_W:0]     dv_ad_ff   [FRAC_BITS];
   logic [COORD_W+1:0]   dv_rem_ff  [FRAC_BITS];
   logic [FRAC_BITS-1:0] dv_quo_ff  [FRAC_BITS];

   for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
      logic                 vld_i;
      logic                 mode_i;
      logic                 zs_i;
      logic                 tz_i;
      logic                 sat_i;
      seg_type              seg_i;
      logic [COORD_W:0]     ad_i;
      logic [COORD_W+1:0]   rem_i;
      logic [FRAC_BITS-1:0] quo_i;
      logic [COORD_W+1:0]   rem2;
      logic                 ge;
      logic [COORD_W+1:0]   rem_in;
      logic [FRAC_BITS-1:0] quo_in;

      if (k == 0) begin : g_first
         assign vld_i  = s2_vld_ff;
         assign mode_i = s2_mode_ff;
         assign zs_i   = s2_zs_ff;
         assign tz_i   = s2_tz_ff;
         assign sat_i  = (s2_an_ff >= s2_ad_ff);
         assign seg_i  = s2_seg_ff;
         assign ad_i   = s2_ad_ff;
         assign rem_i  = {1'b0, s2_an_ff};
         assign quo_i  = '0;
      end else begin : g_next
         assign vld_i  = dv_vld_ff[k-1];
         assign mode_i = dv_mode_ff[k-1];
         assign zs_i   = dv_zs_ff[k-1];
         assign tz_i   = dv_tz_ff[k-1];
         assign sat_i  = dv_sat_ff[k-1];
         assign seg_i  = dv_seg_ff[k-1];
         assign ad_i   = dv_ad_ff[k-1];
         assign rem_i  = dv_rem_ff[k-1];
         assign quo_i  = dv_quo_ff[k-1];
      end

      always_comb begin
         rem2   = {rem_i[COORD_W:0], 1'b0};
         ge     = (rem2 >= {1'b0, ad_i});
         rem_in = ge ? (rem2 - {1'b0, ad_i}) : rem2;
         quo_in = quo_i;
         quo_in[FRAC_BITS-1-k] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[k] <= 1'b0;
         end else begin
            dv_vld_ff[k] <= vld_i;
         end
      end

      always_ff @(posedge clock) begin
         dv_mode_ff[k] <= mode_i;
         dv_zs_ff[k]   <= zs_i;
         dv_tz_ff[k]   <= tz_i;
         dv_sat_ff[k]  <= sat_i;
         dv_seg_ff[k]  <= seg_i;
         dv_ad_ff[k]   <= ad_i;
         dv_rem_ff[k]  <= rem_in;
         dv_quo_ff[k]  <= quo_in;
      end
   end

   // normalized time
   logic [FRAC_BITS:0] t_src;
   always_comb begin
      if (dv_tz_ff[FRAC_BITS-1]) begin
         t_src = '0;
      end else if (dv_sat_ff[FRAC_BITS-1]) begin
         t_src = (FRAC_BITS+1)'(1) << FRAC_BITS;
      end else begin
         t_src = {1'b0, dv_quo_ff[FRAC_BITS-1]};
      end
   end

   // de casteljau levels, three stages each
   carry_type           lv_ff  [NLV];
   logic                lv_vld_ff [NLV];
   logic [FRAC_BITS:0]  lt_ff  [NLV];
   carry_type           lv_src;
   carry_type           m2;
   carry_type           m5;
   carry_type           fin;

   coord_type          la [12];
   coord_type          lb [12];
   coord_type          lr [12];
   logic [FRAC_BITS:0] lt [12];

   always_comb begin
      lv_src      = '0;
      lv_src.mode = dv_mode_ff[FRAC_BITS-1];
      lv_src.zs   = dv_zs_ff[FRAC_BITS-1];
      lv_src.seg  = dv_seg_ff[FRAC_BITS-1];

      m2       = lv_ff[2];
      m2.q01   = '{x: lr[0], y: lr[1]};
      m2.q12   = '{x: lr[2], y: lr[3]};
      m2.q23   = '{x: lr[4], y: lr[5]};

      m5       = lv_ff[5];
      m5.r0    = '{x: lr[6], y: lr[7]};
      m5.r1    = '{x: lr[8], y: lr[9]};

      fin      = lv_ff[8];
      fin.s    = '{x: lr[10], y: lr[11]};
   end

   always_comb begin
      la[0]  = lv_src.seg.p0.x;  lb[0]  = lv_src.seg.p1.x;
      la[1]  = lv_src.seg.p0.y;  lb[1]  = lv_src.seg.p1.y;
      la[2]  = lv_src.seg.p1.x;  lb[2]  = lv_src.seg.p2.x;
      la[3]  = lv_src.seg.p1.y;  lb[3]  = lv_src.seg.p2.y;
      la[4]  = lv_src.seg.p2.x;  lb[4]  = lv_src.seg.p3.x;
      la[5]  = lv_src.seg.p2.y;  lb[5]  = lv_src.seg.p3.y;
      la[6]  = m2.q01.x;         lb[6]  = m2.q12.x;
      la[7]  = m2.q01.y;         lb[7]  = m2.q12.y;
      la[8]  = m2.q12.x;         lb[8]  = m2.q23.x;
      la[9]  = m2.q12.y;         lb[9]  = m2.q23.y;
      la[10] = m5.r0.x;          lb[10] = m5.r1.x;
      la[11] = m5.r0.y;          lb[11] = m5.r1.y;
      for (int i = 0; i < 6; i++) begin
         lt[i] = t_src;
      end
      for (int i = 6; i < 10; i++) begin
         lt[i] = lt_ff[2];
      end
      lt[10] = lt_ff[5];
      lt[11] = lt_ff[5];
   end

   for (genvar i = 0; i < 12; i++) begin : g_lerp
      cbz_lerp #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lerp (
         .clock (clock),
         .a     (la[i]),
         .b     (lb[i]),
         .t     (lt[i]),
         .r     (lr[i])
      );
   end

   for (genvar j = 0; j < NLV; j++) begin : g_lv
      always_ff @(posedge clock) begin
         if (reset) begin
            lv_vld_ff[j] <= 1'b0;
         end else if (j == 0) begin
            lv_vld_ff[j] <= dv_vld_ff[FRAC_BITS-1];
         end else begin
            lv_vld_ff[j] <= lv_vld_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (j == 0) begin
            lv_ff[j] <= lv_src;
            lt_ff[j] <= t_src;
         end else if (j == 3) begin
            lv_ff[j] <= m2;
            lt_ff[j] <= lt_ff[j-1];
         end else if (j == 6) begin
            lv_ff[j] <= m5;
            lt_ff[j] <= lt_ff[j-1];
         end else begin
            lv_ff[j] <= lv_ff[j-1];
            lt_ff[j] <= lt_ff[j-1];
         end
      end
   end

   // output sequencer
   logic       rsp_strobe_ff, rsp_strobe_in;
   point_type  rsp_pt_ff, rsp_pt_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_zs_ff, rsp_zs_in;
   point_type  buf_ff [SPLIT_LEFT];
   point_type  buf_in [SPLIT_LEFT];
   logic       buf_zs_ff, buf_zs_in;
   logic [2:0] left_ff, left_in;
   logic       pend_ff, pend_in;

   always_comb begin
      rsp_strobe_in = 1'b0;
      rsp_pt_in     = rsp_pt_ff;
      rsp_last_in   = 1'b0;
      rsp_zs_in     = rsp_zs_ff;
      buf_in        = buf_ff;
      buf_zs_in     = buf_zs_ff;
      left_in       = left_ff;
      pend_in       = pend_ff;
      if (accept && (req_mode == MODE_SPLIT)) begin
         pend_in = 1'b1;
      end
      if (lv_vld_ff[NLV-1]) begin
         rsp_strobe_in = 1'b1;
         rsp_zs_in     = fin.zs;
         if (fin.mode == MODE_EVAL) begin
            rsp_pt_in   = '{x: '0, y: fin.s.y};
            rsp_last_in = 1'b1;
         end else begin
            rsp_pt_in   = fin.seg.p0;
            buf_in[0]   = fin.q01;
            buf_in[1]   = fin.r0;
            buf_in[2]   = fin.s;
            buf_in[3]   = fin.r1;
            buf_in[4]   = fin.q23;
            buf_in[5]   = fin.seg.p3;
            buf_zs_in   = fin.zs;
            left_in     = 3'(SPLIT_LEFT);
         end
      end else if (left_ff != '0) begin
         rsp_strobe_in = 1'b1;
         rsp_pt_in     = buf_ff[0];
         rsp_zs_in     = buf_zs_ff;
         rsp_last_in   = (left_ff == 3'd1);
         for (int i = 0; i < SPLIT_LEFT - 1; i++) begin
            buf_in[i] = buf_ff[i+1];
         end
         left_in = left_ff - 3'd1;
         if (left_ff == 3'd1) begin
            pend_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
         left_ff       <= '0;
         pend_ff       <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
         left_ff       <= left_in;
         pend_ff       <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pt_ff   <= rsp_pt_in;
      rsp_last_ff <= rsp_last_in;
      rsp_zs_ff   <= rsp_zs_in;
      buf_ff      <= buf_in;
      buf_zs_ff   <= buf_zs_in;
   end

   assign busy           = pend_ff;
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_point_x    = rsp_pt_ff.x;
   assign rsp_point_y    = rsp_pt_ff.y;
   assign rsp_last_point = rsp_last_ff;
   assign rsp_zero_span  = rsp_zs_ff;

   // checks
   a_split_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_mode == MODE_SPLIT)) |=> busy)
      else $error("split word accepted without busy");

   a_left_busy : assert property (@(posedge clock) disable iff (reset)
      (left_ff != '0) |-> pend_ff)
      else $error("split output running while not busy");

   a_no_collide : assert property (@(posedge clock) disable iff (reset)
      lv_vld_ff[NLV-1] |-> (left_ff == '0))
      else $error("pipeline word meets running split output");

   a_split_run : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_point) |=> rsp_strobe)
      else $error("gap inside split output");

endmodule
`default_nettype wire

// ===== dv/cubic_bezier_eval_split_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bezier_eval_split_tb
// drives keyframe segments in evaluate and split mode with random gaps, works
// out the expected curve value or the seven de casteljau points of each word
// and compares every result word field by field in arrival order
// ----------------------------------------------------------------------------
module cubic_bezier_eval_split_tb;
   import cbz_pkg::*;

   typedef struct {
      coord_type x;
      coord_type y;
      logic      last;
      logic      zs;
   } bez_word_type;

   class bezier_scoreboard;
      bez_word_type pending[$];
      int        n_err;
      int        n_seen;
      int        n_eval;
      int        n_split;
      int        n_zero;

      function longint floor_frac(longint p);
         return p >>> CBZ_FRAC_BITS;
      endfunction

      function longint blend(longint a, longint b, longint t);
         return a + floor_frac((b - a) * t + (64'sd1 <<< (CBZ_FRAC_BITS - 1)));
      endfunction

      function longint unit_time(longint num, longint den);
         longint an;
         longint ad;
         if (num == 0 || ((num < 0) != (den < 0))) return 0;
         an = num < 0 ? -num : num;
         ad = den < 0 ? -den : den;
         if (an >= ad) return 64'sd1 <<< CBZ_FRAC_BITS;
         return (an <<< CBZ_FRAC_BITS) / ad;
      endfunction

      function void push_pt(longint x, longint y, logic last, logic zs);
         bez_word_type w;
         w.x = coord_type'(x);
         w.y = coord_type'(y);
         w.last = last;
         w.zs = zs;
         pending.insert(pending.size(), w);
      endfunction

      function void note_segment(logic mode, coord_type qt, seg_type sg);
         longint px[4];
         longint py[4];
         longint ax[3], ay[3], bx[2], by[2], sx, sy, t, den;
         logic   zs;
         px[0] = sg.p0.x; py[0] = sg.p0.y; px[1] = sg.p1.x; py[1] = sg.p1.y;
         px[2] = sg.p2.x; py[2] = sg.p2.y; px[3] = sg.p3.x; py[3] = sg.p3.y;
         den = px[3] - px[0];
         zs = (den == 0);
         t = zs ? 0 : unit_time(longint'(qt) - px[0], den);
         for (int i = 0; i < 3; i++) begin
            ax[i] = blend(px[i], px[i+1], t);
            ay[i] = blend(py[i], py[i+1], t);
         end
         for (int i = 0; i < 2; i++) begin
            bx[i] = blend(ax[i], ax[i+1], t);
            by[i] = blend(ay[i], ay[i+1], t);
         end
         sx = blend(bx[0], bx[1], t);
         sy = blend(by[0], by[1], t);
         if (zs) n_zero++;
         if (mode == MODE_EVAL) begin
            n_eval++;
            push_pt(0, sy, 1'b1, zs);
         end else begin
            n_split++;
            push_pt(px[0], py[0], 1'b0, zs);
            push_pt(ax[0], ay[0], 1'b0, zs);
            push_pt(bx[0], by[0], 1'b0, zs);
            push_pt(sx, sy, 1'b0, zs);
            push_pt(bx[1], by[1], 1'b0, zs);
            push_pt(ax[2], ay[2], 1'b0, zs);
            push_pt(px[3], py[3], 1'b1, zs);
         end
      endfunction

      function void check_word(coord_type x, coord_type y, logic last, logic zs);
         bez_word_type e;
         n_seen++;
         if (pending.size() == 0) begin
            $error("unexpected result word x=%0d y=%0d", x, y);
            n_err++;
            return;
         end
         e = pending.pop_front();
         if (x !== e.x) begin
            $error("point_x expected %0d actual %0d", e.x, x); n_err++;
         end
         if (y !== e.y) begin
            $error("point_y expected %0d actual %0d", e.y, y); n_err++;
         end
         if (last !== e.last) begin
            $error("last_point expected %0b actual %0b", e.last, last); n_err++;
         end
         if (zs !== e.zs) begin
            $error("zero_span expected %0b actual %0b", e.zs, zs); n_err++;
         end
      endfunction
   endclass

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   logic      req_mode = 1'b0;
   coord_type req_query_time = '0;
   seg_type   req_seg = '0;
   logic      rsp_strobe;
   coord_type rsp_point_x;
   coord_type rsp_point_y;
   logic      rsp_last_point;
   logic      rsp_zero_span;

   bezier_scoreboard sb = new();

   cubic_bezier_eval_split u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_query_time   (req_query_time),
      .req_start_x      (req_seg.p0.x),
      .req_start_y      (req_seg.p0.y),
      .req_out_handle_x (req_seg.p1.x),
      .req_out_handle_y (req_seg.p1.y),
      .req_in_handle_x  (req_seg.p2.x),
      .req_in_handle_y  (req_seg.p2.y),
      .req_end_x        (req_seg.p3.x),
      .req_end_y        (req_seg.p3.y),
      .rsp_strobe       (rsp_strobe),
      .rsp_point_x      (rsp_point_x),
      .rsp_point_y      (rsp_point_y),
      .rsp_last_point   (rsp_last_point),
      .rsp_zero_span    (rsp_zero_span)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_word(rsp_point_x, rsp_point_y, rsp_last_point, rsp_zero_span);
   end

   // one word, held until taken; start stays high if another follows at once
   task automatic send_segment(logic mode, coord_type qt, seg_type sg, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_mode <= mode;
      req_query_time <= qt;
      req_seg <= sg;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_segment(mode, qt, sg);
   endtask

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 5))
         0: return coord_type'($urandom);
         1: return coord_type'(32'h7fffffff);
         2: return coord_type'(32'h80000000);
         default: return coord_type'($signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000);
      endcase
   endfunction

   task automatic send_random(int gap);
      seg_type   sg;
      coord_type qt;
      logic      mode;
      mode = $urandom_range(0, 1);
      sg.p0.x = rand_coord(); sg.p0.y = rand_coord();
      sg.p1.x = rand_coord(); sg.p1.y = rand_coord();
      sg.p2.x = rand_coord(); sg.p2.y = rand_coord();
      sg.p3.y = rand_coord();
      case ($urandom_range(0, 9))
         0: sg.p3.x = sg.p0.x;
         1: sg.p3.x = rand_coord();
         default: sg.p3.x = sg.p0.x + coord_type'($urandom_range(1, 32'h3ffffff));
      endcase
      case ($urandom_range(0, 7))
         0: qt = rand_coord();
         1: qt = sg.p0.x;
         2: qt = sg.p3.x;
         default: qt = sg.p0.x + coord_type'((longint'(sg.p3.x) - longint'(sg.p0.x))
                       * $urandom_range(0, 1000) / 1000);
      endcase
      send_segment(mode, qt, sg, gap);
   endtask

   initial begin
      seg_type   sg;
      coord_type lim[4];
      int        wait_n;
      lim[0] = coord_type'(32'h7fffffff);
      lim[1] = coord_type'(32'h80000000);
      lim[2] = '0;
      lim[3] = coord_type'(32'hffffffff);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // typical segment across t = 0, interior, 1 and beyond, both modes
      sg = '{p0: '{32'sh10000, 32'sh0}, p1: '{32'sh20000, 32'sh30000},
             p2: '{32'sh30000, -32'sh30000}, p3: '{32'sh40000, 32'sh10000}};
      foreach (lim[i]) send_segment(MODE_EVAL, lim[i], sg, 0);
      send_segment(MODE_EVAL, 32'sh28000, sg, 0);
      send_segment(MODE_SPLIT, 32'sh28000, sg, 1);
      send_segment(MODE_SPLIT, 32'sh5000, sg, 0);
      send_segment(MODE_SPLIT, 32'sh50000, sg, 2);
      // reversed segment, zero span, and extreme coordinates
      sg.p3.x = -32'sh40000;
      send_segment(MODE_EVAL, -32'sh8000, sg, 0);
      send_segment(MODE_SPLIT, -32'sh8000, sg, 0);
      sg.p3.x = sg.p0.x;
      send_segment(MODE_EVAL, 32'sh28000, sg, 0);
      send_segment(MODE_SPLIT, 32'sh28000, sg, 0);
      foreach (lim[i]) begin
         sg = '{p0: '{lim[i], lim[(i+1)%4]}, p1: '{lim[(i+2)%4], lim[(i+3)%4]},
                p2: '{lim[(i+1)%4], lim[i]}, p3: '{lim[(i+3)%4], lim[(i+2)%4]}};
         send_segment(MODE_EVAL, lim[(i+2)%4], sg, 0);
         send_segment(MODE_SPLIT, lim[(i+1)%4], sg, 0);
      end
      for (int n = 0; n < 360; n++) begin
         wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
         if ((n / 40) % 3 == 1) wait_n = 0;
         send_random(wait_n);
      end
      start <= 1'b0;
      wait_n = 0;
      while (sb.pending.size() != 0 && wait_n < 5000) begin
         @(posedge clock);
         wait_n++;
      end
      repeat (40) @(posedge clock);
      $display("covered %0d evaluate and %0d split segments, %0d with zero span",
               sb.n_eval, sb.n_split, sb.n_zero);
      $display("checked %0d result words", sb.n_seen);
      if (sb.n_err == 0 && sb.pending.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
